### hdl/utf8ws_pkg.sv
package utf8ws_pkg;

  localparam int CpWidth = 21;

  localparam logic [7:0] LeadMask2 = 8'hE0;
  localparam logic [7:0] LeadCode2 = 8'hC0;
  localparam logic [7:0] LeadMask3 = 8'hF0;
  localparam logic [7:0] LeadCode3 = 8'hE0;
  localparam logic [7:0] LeadMask4 = 8'hF8;
  localparam logic [7:0] LeadCode4 = 8'hF0;
  localparam logic [7:0] ContMask  = 8'hC0;
  localparam logic [7:0] ContCode  = 8'h80;

  typedef logic [CpWidth-1:0] cp_t;
  typedef logic [1:0] pending_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_last;
    logic       no_byte;
  } item_t;

  function automatic logic ws_code_point(input cp_t c);
    logic r;
    r = (c >= 21'h00009 && c <= 21'h0000D) ||
        (c >= 21'h0001C && c <= 21'h0001F) ||
        c == 21'h00020 || c == 21'h00085 || c == 21'h000A0 || c == 21'h01680 ||
        (c >= 21'h02000 && c <= 21'h0200A) ||
        c == 21'h02028 || c == 21'h02029 || c == 21'h0202F ||
        c == 21'h0205F || c == 21'h03000;
    return r;
  endfunction

endpackage

### hdl/utf8ws_in_if.sv
interface utf8ws_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       is_last;
  logic       no_byte;

  modport source (output valid, output data_byte, output is_last, output no_byte,
                  input ready);
  modport sink (input valid, input data_byte, input is_last, input no_byte,
                output ready);
endinterface

### hdl/utf8ws_out_if.sv
interface utf8ws_out_if;
  logic valid;
  logic ready;
  logic blank;

  modport source (output valid, output blank, input ready);
  modport sink (input valid, input blank, output ready);
endinterface

### hdl/utf8_whitespace_only_detector_top.sv
// The final item of a text passes the input register; its result is then registered
// in the result register. Throughput: one item per cycle, except while a final item
// waits in the input register until the result register is free; the input register
// and the result register let non-final items enter while a result waits to be taken.
// Reset: synchronous, active low; clears both valid flags and returns the decoder
// to its start state (nothing pending, blank flag set).
module utf8_whitespace_only_detector_top (
  input  logic         clk,
  input  logic         rst_n,
  utf8ws_in_if.sink    in_ch,
  utf8ws_out_if.source out_ch
);

  utf8ws_pkg::item_t in_item;
  utf8ws_pkg::item_t item;
  logic              step;
  logic              out_free;
  logic              dec_blank;
  logic              out_valid_r;
  logic              out_blank_r;

  assign in_item.data_byte = in_ch.data_byte;
  assign in_item.is_last   = in_ch.is_last;
  assign in_item.no_byte   = in_ch.no_byte;

  assign out_free = !out_valid_r || out_ch.ready;

  utf8ws_skid u_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_item  (in_item),
    .out_free (out_free),
    .step     (step),
    .item     (item)
  );

  utf8ws_decode u_dec (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .item  (item),
    .blank (dec_blank)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step && item.is_last) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && item.is_last) begin
      out_blank_r <= dec_blank;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.blank = out_blank_r;

endmodule

### hdl/utf8ws_decode.sv
module utf8ws_decode (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  utf8ws_pkg::item_t   item,
  output logic                blank
);

  utf8ws_pkg::pending_t bytes_pending_r, bytes_pending_nxt;
  utf8ws_pkg::cp_t      partial_r, partial_nxt;
  logic                 still_blank_r, still_blank_nxt;
  utf8ws_pkg::cp_t      cp_ext;
  logic [7:0]           b;

  assign b      = item.data_byte;
  assign cp_ext = {partial_r[utf8ws_pkg::CpWidth-7:0], b[5:0]};

  always_comb begin
    bytes_pending_nxt = bytes_pending_r;
    partial_nxt       = partial_r;
    still_blank_nxt   = still_blank_r;
    if (!item.no_byte) begin
      if (bytes_pending_r == 2'd0) begin
        if (!b[7]) begin
          if (!utf8ws_pkg::ws_code_point({13'd0, b})) begin
            still_blank_nxt = 1'b0;
          end
        end else if ((b & utf8ws_pkg::LeadMask2) == utf8ws_pkg::LeadCode2) begin
          bytes_pending_nxt = 2'd1;
          partial_nxt       = {16'd0, b[4:0]};
        end else if ((b & utf8ws_pkg::LeadMask3) == utf8ws_pkg::LeadCode3) begin
          bytes_pending_nxt = 2'd2;
          partial_nxt       = {17'd0, b[3:0]};
        end else if ((b & utf8ws_pkg::LeadMask4) == utf8ws_pkg::LeadCode4) begin
          bytes_pending_nxt = 2'd3;
          partial_nxt       = {18'd0, b[2:0]};
        end else begin
          still_blank_nxt = 1'b0;
        end
      end else if ((b & utf8ws_pkg::ContMask) != utf8ws_pkg::ContCode) begin
        still_blank_nxt   = 1'b0;
        bytes_pending_nxt = 2'd0;
        partial_nxt       = '0;
      end else begin
        bytes_pending_nxt = bytes_pending_r - 2'd1;
        partial_nxt       = cp_ext;
        if (bytes_pending_r == 2'd1) begin
          partial_nxt = '0;
          if (!utf8ws_pkg::ws_code_point(cp_ext)) begin
            still_blank_nxt = 1'b0;
          end
        end
      end
    end
  end

  assign blank = still_blank_nxt && (bytes_pending_nxt == 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_pending_r <= 2'd0;
      partial_r       <= '0;
      still_blank_r   <= 1'b1;
    end else if (step) begin
      if (item.is_last) begin
        bytes_pending_r <= 2'd0;
        partial_r       <= '0;
        still_blank_r   <= 1'b1;
      end else begin
        bytes_pending_r <= bytes_pending_nxt;
        partial_r       <= partial_nxt;
        still_blank_r   <= still_blank_nxt;
      end
    end
  end

  a_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
    step && item.is_last |=> bytes_pending_r == 2'd0 && still_blank_r)
    else $error("state not restored after final transfer");

  a_idle_partial_clear: assert property (@(posedge clk) disable iff (!rst_n)
    bytes_pending_r == 2'd0 |-> partial_r == '0)
    else $error("partial code point held with nothing pending");

  a_empty_item_holds: assert property (@(posedge clk) disable iff (!rst_n)
    step && item.no_byte && !item.is_last |=>
      $stable(bytes_pending_r) && $stable(partial_r) && $stable(still_blank_r))
    else $error("empty item changed decode state");

  a_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    !still_blank_r && !(step && item.is_last) |=> !still_blank_r)
    else $error("blank flag set mid-text");

endmodule

### hdl/utf8ws_decode_top_dummy_guard.sv
module utf8ws_skid (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  utf8ws_pkg::item_t in_item,
  input  logic              out_free,
  output logic              step,
  output utf8ws_pkg::item_t item
);

  logic              s1_valid_r;
  utf8ws_pkg::item_t s1_item_r;
  logic              s1_done;

  assign s1_done  = !s1_item_r.is_last || out_free;
  assign step     = s1_valid_r && s1_done;
  assign in_ready = !s1_valid_r || s1_done;
  assign item     = s1_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r <= in_item;
    end
  end

endmodule
